// ===== hw/rtl/uer_pkg.sv =====
`default_nettype none

package uer_pkg;

    // Register indexes on the configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MAX_DISTANCE  = 2'd2;

    localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd10;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd30000;
    localparam logic [9:0]  MAX_DISTANCE_RST  = 10'd400;

    // Distance is width * 17 / 1000, built up one tick at a time.
    localparam logic [10:0] CM_STEP = 11'd17;
    localparam logic [10:0] CM_DIV  = 11'd1000;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_RISE = 2'd2,
        PH_HIGH = 2'd3
    } phase_t;

    typedef struct packed {
        logic [9:0]  max_distance;
        logic [15:0] timeout_ticks;
        logic [7:0]  trigger_ticks;
    } cfg_t;

    typedef struct packed {
        logic       busy_res;
        logic       timed_out;
        logic       measure_done;
        logic [7:0] err_count;
        logic [9:0] distance_cm;
        logic       trigger;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uer_cfg.sv =====
`default_nettype none

module uer_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    output uer_pkg::cfg_t                        cfg
);

    uer_pkg::cfg_t cfg_reg;
    uer_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                uer_pkg::CFG_IDX_TRIGGER_TICKS: cfg_next.trigger_ticks = cfg_data[7:0];
                uer_pkg::CFG_IDX_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[15:0];
                uer_pkg::CFG_IDX_MAX_DISTANCE:  cfg_next.max_distance  = cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ticks <= uer_pkg::TRIGGER_TICKS_RST;
            cfg_reg.timeout_ticks <= uer_pkg::TIMEOUT_TICKS_RST;
            cfg_reg.max_distance  <= uer_pkg::MAX_DISTANCE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/uer_ctrl.sv =====
`default_nettype none

module uer_ctrl #(
    parameter int ERR_COUNT_BITS = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire logic          start_req,
    input  wire logic          echo,
    input  wire uer_pkg::cfg_t cfg,
    output uer_pkg::res_t      res
);

    uer_pkg::phase_t               phase_reg,  phase_next;
    logic [15:0]                   ticks_reg,  ticks_next;
    logic [15:0]                   width_reg,  width_next;
    logic [9:0]                    rem_reg,    rem_next;
    logic [10:0]                   dist_reg,   dist_next;
    logic [9:0]                    last_reg,   last_next;
    logic [ERR_COUNT_BITS-1:0]     errors_reg, errors_next;

    uer_pkg::phase_t phase_cur;
    logic [15:0]     ticks_cur;
    logic [15:0]     ticks_inc;
    logic [7:0]      trig_len;
    logic [10:0]     rem_sum;
    logic            timeout_hit;
    logic            trig_out;
    logic            done;
    logic [31:0]     errors_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= uer_pkg::PH_IDLE;
            ticks_reg  <= '0;
            width_reg  <= '0;
            rem_reg    <= '0;
            dist_reg   <= '0;
            last_reg   <= '0;
            errors_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            ticks_reg  <= ticks_next;
            width_reg  <= width_next;
            rem_reg    <= rem_next;
            dist_reg   <= dist_next;
            last_reg   <= last_next;
            errors_reg <= errors_next;
        end
    end

    always_comb begin
        trig_len    = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;
        phase_cur   = phase_reg;
        ticks_cur   = ticks_reg;
        if (phase_reg == uer_pkg::PH_IDLE && start_req) begin
            phase_cur = uer_pkg::PH_TRIG;
            ticks_cur = '0;
        end
        ticks_inc   = 16'(ticks_cur + 16'd1);
        rem_sum     = 11'({1'b0, rem_reg} + uer_pkg::CM_STEP);

        phase_next  = phase_cur;
        ticks_next  = ticks_cur;
        width_next  = width_reg;
        rem_next    = rem_reg;
        dist_next   = dist_reg;
        last_next   = last_reg;
        errors_next = errors_reg;
        trig_out    = 1'b0;
        done        = 1'b0;
        timeout_hit = 1'b0;

        unique case (phase_cur)
            uer_pkg::PH_IDLE: ;
            uer_pkg::PH_TRIG: begin
                trig_out = 1'b1;
                if (ticks_inc >= {8'd0, trig_len}) begin
                    phase_next = uer_pkg::PH_RISE;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_inc;
                end
            end
            uer_pkg::PH_RISE: begin
                if (echo) begin
                    // The rising tick already counts as one tick of width.
                    phase_next = uer_pkg::PH_HIGH;
                    ticks_next = '0;
                    width_next = 16'd1;
                    rem_next   = uer_pkg::CM_STEP[9:0];
                    dist_next  = '0;
                end else if (ticks_cur >= cfg.timeout_ticks) begin
                    timeout_hit = 1'b1;
                end else begin
                    ticks_next = ticks_inc;
                end
            end
            uer_pkg::PH_HIGH: begin
                if (echo) begin
                    if (width_reg >= cfg.timeout_ticks) begin
                        timeout_hit = 1'b1;
                    end else begin
                        width_next = 16'(width_reg + 16'd1);
                        if (rem_sum >= uer_pkg::CM_DIV) begin
                            rem_next  = 10'(rem_sum - uer_pkg::CM_DIV);
                            dist_next = 11'(dist_reg + 11'd1);
                        end else begin
                            rem_next  = rem_sum[9:0];
                        end
                    end
                end else begin
                    done       = 1'b1;
                    phase_next = uer_pkg::PH_IDLE;
                    ticks_next = '0;
                    if (dist_reg != 11'd0 && dist_reg <= {1'b0, cfg.max_distance}) begin
                        last_next   = dist_reg[9:0];
                        errors_next = '0;
                    end
                end
            end
            default: ;
        endcase

        if (timeout_hit) begin
            done       = 1'b1;
            phase_next = uer_pkg::PH_IDLE;
            ticks_next = '0;
            if (errors_reg != {ERR_COUNT_BITS{1'b1}}) begin
                errors_next = ERR_COUNT_BITS'(errors_reg + 1'b1);
            end
        end

        errors_wide      = 32'(errors_next);
        res.trigger      = trig_out;
        res.distance_cm  = last_next;
        res.err_count    = (errors_wide > 32'd255) ? 8'hFF : errors_wide[7:0];
        res.measure_done = done;
        res.timed_out    = timeout_hit;
        res.busy_res     = (phase_next != uer_pkg::PH_IDLE);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranging controller.
// Each input beat on the s_ channel is one microsecond tick carrying the start
// request and the sampled echo pin. Every accepted beat produces exactly one
// result beat on the m_ channel with the trigger pin level, the last valid
// distance in centimetres, the timeout count since the last valid distance and the done,
// timed-out and busy flags, all showing the state after that tick.
// A beat passes an input register and then the control logic into the result
// register, and one beat is taken every cycle in steady flow while m_tready
// stays high. The tick-to-tick state loop closes through the controller
// registers, with the distance built up by adding 17 per echo tick into a
// remainder against 1000.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more; s_tready drops only once both are full.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect on the next
// tick and are meant to be made while no measurement runs.
// Synchronous active-low reset returns the controller to idle, clears the
// distance and error count, loads the default register values and empties
// both pipeline registers.
`default_nettype none

module ultrasonic_echo_ranger #(
    parameter int ERR_COUNT_BITS = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output wire logic                            s_tready,
    // bit 0 start_req, bit 1 echo, bits 7:2 zero
    input  wire logic [uer_pkg::S_TDATA_W-1:0]   s_tdata,
    output wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // bit 0 trigger, 10:1 distance_cm, 18:11 err_count, 19 measure_done,
    // 20 timed_out, 21 busy_res, 23:22 zero
    output wire logic [uer_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data
);

    uer_pkg::cfg_t cfg;
    uer_pkg::res_t res;

    logic       in_valid_reg, in_valid_next;
    logic [1:0] in_data_reg;
    logic       out_valid_reg, out_valid_next;
    logic [uer_pkg::M_TDATA_W-1:0] out_data_reg;
    logic       fire;
    logic       in_ready;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign in_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next  = in_ready ? s_tvalid : in_valid_reg;
        out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && in_ready) begin
            in_data_reg <= s_tdata[1:0];
        end
        if (fire) begin
            out_data_reg <= {2'b00, res};
        end
    end

    uer_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uer_ctrl #(
        .ERR_COUNT_BITS (ERR_COUNT_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (fire),
        .start_req (in_data_reg[0]),
        .echo      (in_data_reg[1]),
        .cfg       (cfg),
        .res       (res)
    );

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/uer_checker.sv =====
`default_nettype none

module uer_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [uer_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat must stay put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A timeout is always reported as the end of a measurement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] |-> m_tdata[19])
        else $error("timed_out without measure_done");

    // The ending tick leaves the controller idle with the trigger released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> !m_tdata[21] && !m_tdata[0])
        else $error("measure_done while busy or triggering");

    // The trigger is only driven during a measurement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[21])
        else $error("trigger driven while idle");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/uer_checker.sv =====
`timescale 1ns / 100ps

module uer_scoreboard #(
    parameter int ERR_COUNT_BITS = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    // bit 0 start_req, bit 1 echo, bits 7:2 zero
    input  wire logic [uer_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // bit 0 trigger, 10:1 distance_cm, 18:11 err_count, 19 measure_done,
    // 20 timed_out, 21 busy_res, 23:22 zero
    input  wire logic [uer_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                   fail_count,
    output int                                   pending
);

    localparam int unsigned ERR_CEILING = (1 << ERR_COUNT_BITS) - 1;
    localparam int          RES_W       = $bits(uer_pkg::res_t);

    // Shadow of the controller: register copies and measurement state.
    logic [7:0]      trig_cfg;
    logic [15:0]     tmo_cfg;
    logic [9:0]      max_cfg;
    uer_pkg::phase_t ph;
    logic [15:0]     ph_ticks;
    logic [15:0]     echo_w;
    logic [9:0]      last_dist;
    int unsigned     errs;

    uer_pkg::res_t tick_reports_q[$];
    int            fails = 0;

    function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fails++;
        end
    endfunction

    task automatic end_by_timeout(inout uer_pkg::res_t r);
        if (errs < ERR_CEILING) begin
            errs++;
        end
        r.measure_done = 1'b1;
        r.timed_out    = 1'b1;
        ph             = uer_pkg::PH_IDLE;
        ph_ticks       = '0;
    endtask

    // Advances the shadow by one microsecond tick and returns the report beat it yields.
    task automatic advance_tick(input logic start, input logic echo,
                                output uer_pkg::res_t r);
        logic [15:0] trig_len;
        int unsigned cm;
        r        = '0;
        trig_len = (trig_cfg == 8'd0) ? 16'd1 : 16'(trig_cfg);
        if (ph == uer_pkg::PH_IDLE && start) begin
            ph       = uer_pkg::PH_TRIG;
            ph_ticks = '0;
        end
        case (ph)
            uer_pkg::PH_TRIG: begin
                r.trigger = 1'b1;
                ph_ticks++;
                if (ph_ticks >= trig_len) begin
                    ph       = uer_pkg::PH_RISE;
                    ph_ticks = '0;
                end
            end
            uer_pkg::PH_RISE: begin
                if (echo) begin
                    ph       = uer_pkg::PH_HIGH;
                    echo_w   = 16'd1;
                    ph_ticks = '0;
                end else if (ph_ticks >= tmo_cfg) begin
                    end_by_timeout(r);
                end else begin
                    ph_ticks++;
                end
            end
            uer_pkg::PH_HIGH: begin
                if (echo) begin
                    if (echo_w >= tmo_cfg) begin
                        end_by_timeout(r);
                    end else begin
                        echo_w++;
                    end
                end else begin
                    cm = (32'(echo_w) * 32'(uer_pkg::CM_STEP)) / 32'(uer_pkg::CM_DIV);
                    if (cm >= 1 && cm <= 32'(max_cfg)) begin
                        last_dist = cm[9:0];
                        errs      = 0;
                    end
                    r.measure_done = 1'b1;
                    ph             = uer_pkg::PH_IDLE;
                    ph_ticks       = '0;
                end
            end
            default: begin
            end
        endcase
        r.distance_cm = last_dist;
        r.err_count   = (errs > 255) ? 8'd255 : 8'(errs);
        r.busy_res    = (ph != uer_pkg::PH_IDLE);
    endtask

    always @(posedge aclk) begin
        uer_pkg::res_t want;
        uer_pkg::res_t got;
        if (!aresetn) begin
            trig_cfg  = uer_pkg::TRIGGER_TICKS_RST;
            tmo_cfg   = uer_pkg::TIMEOUT_TICKS_RST;
            max_cfg   = uer_pkg::MAX_DISTANCE_RST;
            ph        = uer_pkg::PH_IDLE;
            ph_ticks  = '0;
            echo_w    = '0;
            last_dist = '0;
            errs      = 0;
            tick_reports_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    uer_pkg::CFG_IDX_TRIGGER_TICKS: trig_cfg = cfg_data[7:0];
                    uer_pkg::CFG_IDX_TIMEOUT_TICKS: tmo_cfg  = cfg_data[15:0];
                    uer_pkg::CFG_IDX_MAX_DISTANCE:  max_cfg  = cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
            // Outgoing beats are matched before this edge's incoming beat is predicted.
            if (m_tvalid && m_tready) begin
                got = uer_pkg::res_t'(m_tdata[RES_W-1:0]);
                if (tick_reports_q.size() == 0) begin
                    $error("result beat arrived with no expectation waiting");
                    fails++;
                end else begin
                    want = tick_reports_q.pop_front();
                    check_field("trigger", want.trigger, got.trigger);
                    check_field("distance_cm", want.distance_cm, got.distance_cm);
                    check_field("err_count", want.err_count, got.err_count);
                    check_field("measure_done", want.measure_done, got.measure_done);
                    check_field("timed_out", want.timed_out, got.timed_out);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("padding", 0, m_tdata[uer_pkg::M_TDATA_W-1:RES_W]);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_tick(s_tdata[0], s_tdata[1], want);
                tick_reports_q.push_back(want);
            end
        end
        pending    <= tick_reports_q.size();
        fail_count <= fails;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int ERR_BITS    = 8;
    localparam int CYCLE_LIMIT = 40000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_ITEMS = 20;
    localparam int S_W         = uer_pkg::S_TDATA_W;
    localparam int M_W         = uer_pkg::M_TDATA_W;
    localparam int IDX_W       = uer_pkg::CFG_INDEX_W;
    localparam int CFG_W       = uer_pkg::CFG_DATA_W;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   cycles      = 0;
    int   items_sent  = 0;
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    logic hold_off    = 1'b0;
    int   trig_shadow = int'(uer_pkg::TRIGGER_TICKS_RST);
    int   tmo_shadow  = int'(uer_pkg::TIMEOUT_TICKS_RST);

    ultrasonic_echo_ranger #(
        .ERR_COUNT_BITS(ERR_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    uer_scoreboard #(
        .ERR_COUNT_BITS(ERR_BITS)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL ultrasonic_echo_ranger");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    // Offers one tick beat, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_tick(input logic start, input logic echo);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({echo, start});
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge aclk);
    endtask

    task automatic set_config(input int trig, input int tmo, input int maxd);
        drain_results();
        write_reg(uer_pkg::CFG_IDX_TRIGGER_TICKS, trig);
        write_reg(uer_pkg::CFG_IDX_TIMEOUT_TICKS, tmo);
        write_reg(uer_pkg::CFG_IDX_MAX_DISTANCE, maxd);
        cfg_we      <= 1'b0;
        trig_shadow = trig;
        tmo_shadow  = tmo;
    endtask

    // One complete measurement. A wait longer than the timeout ends in a rise timeout, and
    // an echo longer than the timeout allows ends in a width timeout.
    task automatic measure(input int wait_len, input int high_len);
        int trig_len;
        int tw;
        trig_len = (trig_shadow == 0) ? 1 : trig_shadow;
        tw       = (tmo_shadow == 0) ? 1 : tmo_shadow;
        send_tick(1'b1, coin());
        repeat (trig_len - 1) send_tick(coin(), coin());
        if (wait_len > tmo_shadow) begin
            repeat (tmo_shadow + 1) send_tick(coin(), 1'b0);
        end else begin
            repeat (wait_len) send_tick(coin(), 1'b0);
            if (high_len > tw) begin
                repeat (tw + 1) send_tick(coin(), 1'b1);
            end else begin
                repeat (high_len) send_tick(coin(), 1'b1);
                send_tick(coin(), 1'b0);
            end
        end
    endtask

    task automatic random_step();
        int tw;
        int kind;
        int wait_len;
        int high_len;
        int span;
        tw   = (tmo_shadow == 0) ? 1 : tmo_shadow;
        kind = $urandom_range(9);
        if (kind == 0) begin
            // Idle noise: the echo pin may wander while nobody asks for a measurement.
            repeat ($urandom_range(1, 4)) send_tick(1'b0, coin());
        end else begin
            wait_len = (kind == 1) ? tmo_shadow + 1
                                   : $urandom_range(0, (tmo_shadow < 12) ? tmo_shadow : 12);
            span     = coin() ? 16 : 80;
            high_len = (kind == 2) ? tw + 1 : $urandom_range(1, (tw < span) ? tw : span);
            measure(wait_len, high_len);
        end
    endtask

    initial begin
        int goal;
        int sender_idle[4];
        int receiver_stall[4];
        sender_idle    = '{0, 60, 0, 29};
        receiver_stall = '{0, 0, 60, 29};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: a stray echo while idle, then an echo too short for a centimetre.
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        measure(2, 3);

        // Zero trigger length and zero timeout, with no distance ever valid.
        set_config(0, 0, 0);
        measure(5, 1);
        measure(0, 5);
        measure(0, 1);

        // Enough back-to-back timeouts to saturate the error counter.
        repeat (255) measure(1, 1);

        // A one-centimetre echo inside a one-centimetre window clears the saturated count.
        set_config(1, 65535, 1);
        measure(0, 59);

        // Longer trigger pulse, shortest non-zero timeout, widest distance window.
        set_config(12, 1, 1023);
        measure(3, 1);
        measure(1, 1);

        for (int p = 0; p < 4; p++) begin
            set_config($urandom_range(0, 8), $urandom_range(0, 80),
                       ($urandom_range(3) == 0) ? 1023 : $urandom_range(0, 6));
            idle_pct  = sender_idle[p];
            stall_pct <= receiver_stall[p];
            goal      = items_sent + PHASE_ITEMS;
            if (p == 0) begin
                // The receiver holds off while the sender keeps offering beats.
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_off <= 1'b0;
                    end
                    repeat (2) random_step();
                join
            end
            while (items_sent < goal) begin
                random_step();
                if (p == 3 && items_sent >= goal - PHASE_ITEMS / 2 && pending > 0) begin
                    drain_results();
                    goal = goal + 1;
                end
            end
        end

        stall_pct <= 0;
        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS ultrasonic_echo_ranger");
        end else begin
            $display("FAIL ultrasonic_echo_ranger");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/uer_pkg.sv
hw/rtl/uer_cfg.sv
hw/rtl/uer_ctrl.sv
hw/rtl/ultrasonic_echo_ranger.sv
hw/rtl/uer_checker.sv
sim/uer_checker.sv
sim/tb_top.sv
